// ----- src/wsht_pkg.sv -----
// shared constants and types for the window stack hit test block
package wsht_pkg;

    localparam int MAX_WINDOWS  = 16;
    localparam int COORD_BITS   = 12;
    localparam int CNT_BITS     = $clog2(MAX_WINDOWS + 1);
    localparam int OUT_NUM_BITS = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLICK  = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] lx;
        logic [COORD_BITS-1:0] ly;
        logic [COORD_BITS-1:0] rx;
        logic [COORD_BITS-1:0] hy;
        logic [CNT_BITS-1:0]   number;
    } t_entry;

    typedef struct packed {
        logic cmp_en;
        logic mov_en;
        logic insert;
        logic any_hit;
    } t_ctrl;

endpackage

// ----- src/wsht_cell.sv -----
// one stack slot: holds a window, tests the click point and shifts down on insert or raise
module wsht_cell (
    input  logic                        i_clk,
    input  wsht_pkg::t_ctrl             i_ctrl,
    input  logic [wsht_pkg::CNT_BITS-1:0]   i_index,
    input  logic [wsht_pkg::CNT_BITS-1:0]   i_count,
    input  logic [wsht_pkg::COORD_BITS-1:0] i_x,
    input  logic [wsht_pkg::COORD_BITS-1:0] i_y,
    input  wsht_pkg::t_entry            i_prev,
    input  wsht_pkg::t_entry            i_sel_dn,
    input  logic                        i_above,
    output wsht_pkg::t_entry            o_entry,
    output wsht_pkg::t_entry            o_sel_up,
    output logic                        o_above
);
    import wsht_pkg::*;

    t_entry r_entry;
    logic   r_match;
    logic   n_match;
    logic   w_load;

    assign n_match = (i_x >= r_entry.lx) && (i_y >= r_entry.ly) &&
                     (i_x <= r_entry.rx) && (i_y <= r_entry.hy) &&
                     (i_index < i_count);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= n_match;
        end
    end

    // topmost match wins: its entry overrides anything coming up from below
    assign o_sel_up = r_match ? r_entry : i_sel_dn;
    assign o_above  = i_above | r_match;

    assign w_load = i_ctrl.mov_en & (i_ctrl.insert | (i_ctrl.any_hit & ~i_above));

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;

endmodule

// ----- src/window_stack_hit_test_raise_core.sv -----
// top level: command sequencing, window count, result register and the row of stack cells
// each input beat is compared in the cell row when accepted, then shifts the row in ST_MOVE,
// which loads the result register; no new input beat is taken while in ST_MOVE, and
// a stalled result beat holds off the shift and thus the next beat
// reset clears the window count and handshake state; slot contents are not cleared
module window_stack_hit_test_raise_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [wsht_pkg::COORD_BITS-1:0]   i_left_x,
    input  logic [wsht_pkg::COORD_BITS-1:0]   i_low_y,
    input  logic [wsht_pkg::COORD_BITS-1:0]   i_right_x,
    input  logic [wsht_pkg::COORD_BITS-1:0]   i_high_y,
    input  logic [wsht_pkg::COORD_BITS-1:0]   i_click_x,
    input  logic [wsht_pkg::COORD_BITS-1:0]   i_click_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [wsht_pkg::OUT_NUM_BITS-1:0] o_window_number,
    output logic                              o_hit,
    output logic                              o_table_full
);
    import wsht_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_MOVE = 1'b1;

    logic                r_state;
    logic                n_state;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_cmd;
    t_entry              r_new;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [CNT_BITS-1:0] r_num;
    logic                r_hit;
    logic                r_full;

    logic   w_accept;
    logic   w_go;
    logic   w_full;
    t_ctrl  w_ctrl;
    t_entry w_top_in;
    t_entry w_entry [MAX_WINDOWS];
    t_entry w_sel   [MAX_WINDOWS+1];
    logic   w_above [MAX_WINDOWS+1];

    assign o_in_stall = (r_state == ST_MOVE);
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_go       = (r_state == ST_MOVE) & (~r_out_valid | ~i_out_stall);
    assign w_full     = (r_count >= CNT_BITS'(MAX_WINDOWS));

    assign w_ctrl.cmp_en  = w_accept;
    assign w_ctrl.mov_en  = w_go & ((r_cmd == CMD_CLICK) | ~w_full);
    assign w_ctrl.insert  = (r_cmd == CMD_INSERT);
    assign w_ctrl.any_hit = w_above[MAX_WINDOWS];

    assign w_top_in = (r_cmd == CMD_INSERT) ? r_new : w_sel[0];

    assign w_sel[MAX_WINDOWS] = '0;
    assign w_above[0]         = 1'b0;

    for (genvar k = 0; k < MAX_WINDOWS; k++) begin : g_cell
        wsht_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_index  (CNT_BITS'(k)),
            .i_count  (r_count),
            .i_x      (i_click_x),
            .i_y      (i_click_y),
            .i_prev   ((k == 0) ? w_top_in : w_entry[(k == 0) ? 0 : k-1]),
            .i_sel_dn (w_sel[k+1]),
            .i_above  (w_above[k]),
            .o_entry  (w_entry[k]),
            .o_sel_up (w_sel[k]),
            .o_above  (w_above[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= i_command;
            r_new.lx     <= i_left_x;
            r_new.ly     <= i_low_y;
            r_new.rx     <= i_right_x;
            r_new.hy     <= i_high_y;
            r_new.number <= r_count + CNT_BITS'(1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid & i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MOVE;
                end
            end
            ST_MOVE: begin
                if (w_go) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if ((r_cmd == CMD_INSERT) && !w_full) begin
                        n_count = r_count + CNT_BITS'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            if (r_cmd == CMD_INSERT) begin
                r_num  <= w_full ? '0 : r_new.number;
                r_hit  <= 1'b0;
                r_full <= w_full;
            end else begin
                r_num  <= w_ctrl.any_hit ? w_sel[0].number : '0;
                r_hit  <= w_ctrl.any_hit;
                r_full <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_window_number = OUT_NUM_BITS'(r_num);
    assign o_hit           = r_hit;
    assign o_table_full    = r_full;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_WINDOWS))
        else $error("window count beyond capacity");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_table_full))
        else $error("hit and table_full both set");

    a_hit_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (r_num != '0 && r_num <= r_count))
        else $error("hit reports an unknown window");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_cmd == CMD_INSERT && !w_full) |=> r_count == $past(r_count) + CNT_BITS'(1))
        else $error("insert did not grow the stack");

    a_click_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (r_cmd == CMD_CLICK || w_full)) |=> $stable(r_count))
        else $error("click or refused insert changed the count");

endmodule
